// ===== sv/kdd_pkg.sv =====
`timescale 1ns / 1ps

package kdd_pkg;

	// default count of keys and of door contacts
	localparam int NUM_SWITCHES_DEF = 7;

	// fixed field widths
	localparam int MODE_W    = 3;
	localparam int SEL_W     = 3;
	localparam int TIMEOUT_W = 16;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_SHIFT_TIMEOUT = 1'b0;

	localparam logic [TIMEOUT_W-1:0] SHIFT_TIMEOUT_RESET = 16'd200;

	// request modes
	typedef enum logic [MODE_W-1:0] {
		MODE_SCAN      = 3'd0,
		MODE_INIT      = 3'd1,
		MODE_CLR_SEL   = 3'd2,
		MODE_CLR_DOOR  = 3'd3,
		MODE_SHIFT_ON  = 3'd4,
		MODE_SHIFT_OFF = 3'd5
	} mode_t;

	// debounce machine states
	typedef enum logic [1:0] {
		ST_LOW     = 2'd0,
		ST_HIGH    = 2'd1,
		ST_CHECKED = 2'd2,
		ST_USED    = 2'd3
	} deb_state_t;

	// what one scan did to a machine
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_CONFIRM = 2'd1,
		EV_RELEASE = 2'd2,
		EV_DROP    = 2'd3
	} deb_event_t;

	typedef struct packed {
		logic scan;
		logic load;
		logic load_used;
	} cell_ctrl_t;

	typedef struct packed {
		logic tick;
		logic start;
		logic stop;
	} shift_ctrl_t;

endpackage

// ===== sv/kdd_cell.sv =====
`timescale 1ns / 1ps

module kdd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kdd_pkg::cell_ctrl_t ctrl,
	input  logic                raw,
	output kdd_pkg::deb_state_t deb_state,
	output kdd_pkg::deb_event_t event_code
);

	kdd_pkg::deb_state_t state_q;
	kdd_pkg::deb_state_t state_nxt;

	always_comb begin
		state_nxt  = state_q;
		event_code = kdd_pkg::EV_NONE;
		case (state_q)
			kdd_pkg::ST_HIGH: begin
				state_nxt = raw ? kdd_pkg::ST_HIGH : kdd_pkg::ST_LOW;
			end
			kdd_pkg::ST_LOW: begin
				state_nxt = raw ? kdd_pkg::ST_HIGH : kdd_pkg::ST_CHECKED;
			end
			kdd_pkg::ST_CHECKED: begin
				if (!raw) begin
					state_nxt  = kdd_pkg::ST_USED;
					event_code = kdd_pkg::EV_CONFIRM;
				end else begin
					state_nxt  = kdd_pkg::ST_HIGH;
					event_code = kdd_pkg::EV_DROP;
				end
			end
			default: begin
				if (raw) begin
					state_nxt  = kdd_pkg::ST_HIGH;
					event_code = kdd_pkg::EV_RELEASE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kdd_pkg::ST_HIGH;
		end else if (ctrl.load) begin
			if (ctrl.load_used) begin
				state_q <= kdd_pkg::ST_USED;
			end else begin
				state_q <= raw ? kdd_pkg::ST_HIGH : kdd_pkg::ST_LOW;
			end
		end else if (ctrl.scan) begin
			state_q <= state_nxt;
		end
	end

	assign deb_state = state_q;

endmodule

// ===== sv/kdd_shift_timer.sv =====
`timescale 1ns / 1ps

module kdd_shift_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kdd_pkg::shift_ctrl_t              ctrl,
	input  logic [kdd_pkg::TIMEOUT_W-1:0]     timeout,
	output logic                              active
);

	logic [kdd_pkg::TIMEOUT_W-1:0] count_q;
	logic                          flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (ctrl.start) begin
			flag_q  <= 1'b1;
			// zero timeout behaves as one tick
			count_q <= (timeout == '0) ? kdd_pkg::TIMEOUT_W'(1) : timeout;
		end else if (ctrl.stop) begin
			flag_q  <= 1'b0;
			count_q <= '0;
		end else if (ctrl.tick && count_q != '0) begin
			count_q <= count_q - kdd_pkg::TIMEOUT_W'(1);
			if (count_q == kdd_pkg::TIMEOUT_W'(1)) begin
				flag_q <= 1'b0;
			end
		end
	end

	assign active = flag_q;

endmodule

// ===== sv/key_and_door_switch_debouncer.sv =====
`timescale 1ns / 1ps

// key and door contact debouncer
//
// request channel: item_valid / item_stall carry mode, key_levels,
// switch_levels, scan_enable and door_level. every request gives exactly one
// result on result_valid / result_stall: selection, door_moved, shift_active
// and the packed debounce states of all contacts and keys (two bits each).
//
// a request sits first in the request register, then in the state update,
// whose registers are the result. throughput is one request per cycle while
// the receiver does not stall; the only limit is the result register, so a
// new request is taken while the previous result is still waiting.
//
// when the receiver stalls, the result stays put and the request register
// fills; item_stall rises only while that register holds a request that
// cannot move on.
//
// reset puts every machine in high, clears selection, door flag and shift
// timer, and loads the shift timeout register with 200 ticks. the timeout
// register sits at byte address 0 of the apb port and should be written idle.

module key_and_door_switch_debouncer #(
	parameter int NUM_SWITCHES = kdd_pkg::NUM_SWITCHES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// request channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [kdd_pkg::MODE_W-1:0]    mode,
	input  logic [NUM_SWITCHES-1:0]       key_levels,
	input  logic [NUM_SWITCHES-1:0]       switch_levels,
	input  logic                          scan_enable,
	input  logic                          door_level,

	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [kdd_pkg::SEL_W-1:0]     selection,
	output logic                          door_moved,
	output logic                          shift_active,
	output logic [2*NUM_SWITCHES-1:0]     door_switch_states,
	output logic [2*NUM_SWITCHES-1:0]     key_state_bits,

	// apb configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kdd_pkg::PADDR_W-1:0]   paddr,
	input  logic [kdd_pkg::PDATA_W-1:0]   pwdata,
	output logic [kdd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int SelW  = kdd_pkg::SEL_W;
	localparam int DataW = kdd_pkg::PDATA_W;
	localparam int TmoW  = kdd_pkg::TIMEOUT_W;

	// configuration register
	logic [TmoW-1:0] shift_timeout_q;
	logic            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == kdd_pkg::REG_SHIFT_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_timeout_q <= kdd_pkg::SHIFT_TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			shift_timeout_q <= pwdata[TmoW-1:0];
		end
	end

	assign prdata = reg_sel ? DataW'(shift_timeout_q) : '0;

	// request register
	logic                        valid_s1;
	logic [kdd_pkg::MODE_W-1:0]  mode_s1;
	logic [NUM_SWITCHES-1:0]     key_levels_s1;
	logic [NUM_SWITCHES-1:0]     switch_levels_s1;
	logic                        scan_enable_s1;
	logic                        door_level_s1;
	logic                        accept;
	logic                        advance;

	// the request moves into the state when the result slot is free
	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1          <= mode;
			key_levels_s1    <= key_levels;
			switch_levels_s1 <= switch_levels;
			scan_enable_s1   <= scan_enable;
			door_level_s1    <= door_level;
		end
	end

	// mode decode for the request leaving stage one
	logic do_scan;
	logic do_init;

	assign do_scan = advance && (mode_s1 == kdd_pkg::MODE_SCAN) && scan_enable_s1;
	assign do_init = advance && (mode_s1 == kdd_pkg::MODE_INIT);

	// debounce machines, one per key and one per contact
	kdd_pkg::deb_state_t key_st [NUM_SWITCHES];
	kdd_pkg::deb_event_t key_ev [NUM_SWITCHES];
	kdd_pkg::deb_state_t sw_st  [NUM_SWITCHES];
	kdd_pkg::deb_event_t sw_ev  [NUM_SWITCHES];

	for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_cell
		kdd_pkg::cell_ctrl_t key_ctrl;
		kdd_pkg::cell_ctrl_t sw_ctrl;

		assign key_ctrl.scan      = do_scan;
		assign key_ctrl.load      = do_init;
		assign key_ctrl.load_used = 1'b0;

		// contact 0 reads as used when the door was closed at init
		assign sw_ctrl.scan      = do_scan;
		assign sw_ctrl.load      = do_init;
		assign sw_ctrl.load_used = (i == 0) && !door_level_s1;

		kdd_cell u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (key_ctrl),
			.raw        (key_levels_s1[i]),
			.deb_state  (key_st[i]),
			.event_code (key_ev[i])
		);

		kdd_cell u_sw (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (sw_ctrl),
			.raw        (switch_levels_s1[i]),
			.deb_state  (sw_st[i]),
			.event_code (sw_ev[i])
		);

		assign key_state_bits[2*i +: 2]     = key_st[i];
		assign door_switch_states[2*i +: 2] = sw_st[i];
	end

	// selection after a scan: keys walked upward, so the highest acting key wins
	logic [SelW-1:0] chosen_q;
	logic [SelW-1:0] sel_scan;

	always_comb begin
		sel_scan = chosen_q;
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			if (key_ev[i] == kdd_pkg::EV_CONFIRM) begin
				sel_scan = SelW'(i + 1);
			end else if (key_ev[i] == kdd_pkg::EV_RELEASE) begin
				sel_scan = '0;
			end
		end
	end

	logic door_flag_q;
	logic door_hit;

	// any change of contact 0 out of checked or used
	assign door_hit = (sw_ev[0] != kdd_pkg::EV_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_q    <= '0;
			door_flag_q <= 1'b0;
		end else if (advance) begin
			case (mode_s1)
				kdd_pkg::MODE_SCAN: begin
					if (scan_enable_s1) begin
						chosen_q    <= sel_scan;
						door_flag_q <= door_flag_q | door_hit;
					end
				end
				kdd_pkg::MODE_INIT: begin
					chosen_q    <= '0;
					door_flag_q <= 1'b0;
				end
				kdd_pkg::MODE_CLR_SEL: begin
					chosen_q <= '0;
				end
				kdd_pkg::MODE_CLR_DOOR: begin
					door_flag_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// shift flag timer, ticks on every scan request even with scanning off
	kdd_pkg::shift_ctrl_t shift_ctrl;

	assign shift_ctrl.tick  = advance && (mode_s1 == kdd_pkg::MODE_SCAN);
	assign shift_ctrl.start = advance && (mode_s1 == kdd_pkg::MODE_SHIFT_ON);
	assign shift_ctrl.stop  = advance && ((mode_s1 == kdd_pkg::MODE_SHIFT_OFF) ||
		(mode_s1 == kdd_pkg::MODE_INIT));

	kdd_shift_timer u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (shift_ctrl),
		.timeout (shift_timeout_q),
		.active  (shift_active)
	);

	// result register: the state itself, flagged by result_valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	assign selection  = chosen_q;
	assign door_moved = door_flag_q;

	// stall only with a request waiting in stage one
	a_stall_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item_stall without a waiting request");

	// init clears selection, door flag and shift flag
	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_init |=> (selection == '0) && !door_moved && !shift_active)
		else $error("init left a flag set");

	// closed door at init puts contact 0 in used
	a_init_door: assert property (@(posedge clk) disable iff (!arst_n)
		(do_init && !door_level_s1) |=> (sw_st[0] == kdd_pkg::ST_USED))
		else $error("contact 0 not used after init with door closed");

	// shift on always raises the flag
	a_shift_on: assert property (@(posedge clk) disable iff (!arst_n)
		shift_ctrl.start |=> shift_active)
		else $error("shift flag not set by shift on");

	// every request taken into the state shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("result missing after state update");

endmodule
